// ===== rtl/device_liveness_hysteresis_table_macros.svh =====
// Assertion macros used by the liveness table datapath.
`ifndef DEVICE_LIVENESS_HYSTERESIS_TABLE_MACROS_SVH
`define DEVICE_LIVENESS_HYSTERESIS_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define DLHT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dlht assertion failed");
// Condition in one cycle that forces a consequence in the next.
`define DLHT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dlht assertion failed");
`else
`define DLHT_ASSERT(label, clk, rst, prop)
`define DLHT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== rtl/dlht_pkg.sv =====
// Types and constants of the device liveness table.
package dlht_pkg;

   localparam int FUNC_BITS      = 2;
   localparam int KEY_FIELD_BITS = 16;
   localparam int SLOT_BITS      = 4;
   localparam int TIME_BITS      = 48;
   localparam int RUN_BITS       = 4;
   localparam int ONLINE_BITS    = 5;
   localparam int ERR_BITS       = 32;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 4;
   localparam int MAX_RESULTS    = 16;
   localparam int ONLINE_SAT     = 31;

   localparam logic [RUN_BITS-1:0] RUN_MAX     = 4'd15;
   localparam logic [ERR_BITS-1:0] ERR_MAX     = 32'hFFFF_FFFF;
   localparam logic [RUN_BITS-1:0] SUCC_THR_RST = 4'd2;
   localparam logic [RUN_BITS-1:0] FAIL_THR_RST = 4'd3;

   typedef enum logic [FUNC_BITS-1:0] {
      FN_SUCCESS = 2'd0,
      FN_FAILURE = 2'd1,
      FN_READ    = 2'd2,
      FN_REPUB   = 2'd3
   } dlht_func_type;

   typedef enum logic [1:0] {
      ST_UNKNOWN = 2'd0,
      ST_ONLINE  = 2'd1,
      ST_OFFLINE = 2'd2
   } dlht_state_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_ONLINE  = 3'd1,
      EV_OFFLINE = 3'd2,
      EV_FULL    = 3'd3,
      EV_REPUB   = 3'd4
   } dlht_event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_SUCC_THR  = 2'd1,
      CSR_FAIL_THR  = 2'd2,
      CSR_PER_DEV   = 2'd3
   } dlht_csr_type;

   typedef struct packed {
      dlht_event_type        event_res;
      logic [SLOT_BITS-1:0]  slot;
      logic [KEY_FIELD_BITS-1:0] key_out;
      logic                  entry_valid;
      dlht_state_type        entry_state;
      logic [TIME_BITS-1:0]  last_ok_ms;
      logic [RUN_BITS-1:0]   fail_run;
      logic [ONLINE_BITS-1:0] online_count;
      logic [ERR_BITS-1:0]   error_total;
      logic                  per_device_report;
      logic                  last;
   } dlht_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic read_slot;
      logic scan_start;
      logic scan_step;
      logic scan_resume;
      logic out_slot;
      logic out_full;
      logic out_pub;
      logic commit;
      logic use_new;
   } dlht_cmd_type;

   // Datapath to controller
   typedef struct packed {
      dlht_func_type func;
      logic          enabled;
      logic          hit;
      logic          scan_done;
      logic          table_full;
      logic          out_free;
      logic          pub_last;
   } dlht_stat_type;

   // Online count as reported, saturating
   function automatic logic [ONLINE_BITS-1:0] online_sat(input logic [31:0] cnt);
      logic [ONLINE_BITS-1:0] res;
      if (cnt > 32'(ONLINE_SAT)) begin
         res = ONLINE_BITS'(ONLINE_SAT);
      end else begin
         res = cnt[ONLINE_BITS-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/dlht_req_if.sv =====
// Request channel: one event or query word per handshake.
interface dlht_req_if;
   import dlht_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_BITS-1:0]      func;
   logic [KEY_FIELD_BITS-1:0] device_key;
   logic [SLOT_BITS-1:0]      slot_index;
   logic [TIME_BITS-1:0]      time_ms;

   modport source(output valid, func, device_key, slot_index, time_ms, input ready);
   modport sink(input valid, func, device_key, slot_index, time_ms, output ready);
endinterface

// ===== rtl/dlht_rsp_if.sv =====
// Response channel: one result word per handshake.
interface dlht_rsp_if;
   import dlht_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [2:0]                event_res;
   logic [SLOT_BITS-1:0]      slot;
   logic [KEY_FIELD_BITS-1:0] key_out;
   logic                      entry_valid;
   logic [1:0]                entry_state;
   logic [TIME_BITS-1:0]      last_ok_ms;
   logic [RUN_BITS-1:0]       fail_run;
   logic [ONLINE_BITS-1:0]    online_count;
   logic [ERR_BITS-1:0]       error_total;
   logic                      per_device_report;
   logic                      last;

   modport source(output valid, event_res, slot, key_out, entry_valid, entry_state,
                  last_ok_ms, fail_run, online_count, error_total,
                  per_device_report, last, input ready);
   modport sink(input valid, event_res, slot, key_out, entry_valid, entry_state,
                last_ok_ms, fail_run, online_count, error_total,
                per_device_report, last, output ready);
endinterface

// ===== rtl/device_liveness_hysteresis_table.sv =====
// Device liveness table with hysteresis: top level.
//
// Each request word carries a function code, a device key, a slot index and
// the current time. Success and failure events look the key up among the
// used slots (or claim the next free one), update its streaks and return one
// result word; a slot read returns one word; a republish returns one word per
// online entry, the final word marked by last. Events and republish return
// nothing while the block is disabled. Configuration writes go through the
// csr_ port; the user is to make them only while the block is idle, as the
// block itself does not enforce this.
// A request is accepted, then started; an event's key scan reads the table
// memory one slot a cycle over the used slots, and the found or claimed
// entry is written back as its result is loaded. A republish resumes the
// scan after each online entry it reports. The table memory has one read port.
// Reset empties the table, clears the error and online counts and restores
// the register defaults; it is immediate, with no clearing pass.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer holds the next result until the receiver takes it.
module device_liveness_hysteresis_table #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [dlht_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dlht_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   dlht_req_if.sink                           req_chan,
   dlht_rsp_if.source                         rsp_chan
);
   import dlht_pkg::*;

   dlht_cmd_type  cmd;
   dlht_stat_type stat;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   dlht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dlht_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BITS    (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_func          (req_chan.func),
      .in_key           (req_chan.device_key),
      .in_slot          (req_chan.slot_index),
      .in_time          (req_chan.time_ms),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_chan         (rsp_chan)
   );
endmodule

// ===== rtl/dlht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dlht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/dlht_ctrl.sv =====
// Sequencer of the liveness table: accept, scan, update and report.
module dlht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dlht_pkg::dlht_stat_type stat,
   output dlht_pkg::dlht_cmd_type  cmd
);
   import dlht_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SLOT,
      S_SCAN,
      S_PUB,
      S_FULL,
      S_UPD
   } state_type;

   state_type state_ff, state_in;
   logic      new_ff, new_in;

   always_comb begin
      state_in  = state_ff;
      new_in    = new_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (stat.func == FN_READ) begin
               cmd.read_slot = 1'b1;
               state_in      = S_SLOT;
            end else if (!stat.enabled) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SLOT: begin
            if (stat.out_free) begin
               cmd.out_slot = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.func == FN_REPUB) begin
                  state_in = S_PUB;
               end else begin
                  new_in   = 1'b0;
                  state_in = S_UPD;
               end
            end else if (stat.scan_done) begin
               if (stat.func == FN_REPUB) begin
                  state_in = S_IDLE;
               end else if (stat.table_full) begin
                  state_in = S_FULL;
               end else begin
                  // claim the lowest free slot
                  new_in   = 1'b1;
                  state_in = S_UPD;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_PUB: begin
            if (stat.out_free) begin
               cmd.out_pub = 1'b1;
               if (stat.pub_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_resume = 1'b1;
                  state_in        = S_SCAN;
               end
            end
         end
         S_FULL: begin
            if (stat.out_free) begin
               cmd.out_full = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_UPD: begin
            cmd.use_new = new_ff;
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         new_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         new_ff   <= new_in;
      end
   end
endmodule

// ===== rtl/dlht_datapath.sv =====
// Table storage, scan counters, entry update and the response register.
`include "device_liveness_hysteresis_table_macros.svh"

module dlht_datapath #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [dlht_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [dlht_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic [dlht_pkg::FUNC_BITS-1:0]        in_func,
   input  logic [dlht_pkg::KEY_FIELD_BITS-1:0]   in_key,
   input  logic [dlht_pkg::SLOT_BITS-1:0]        in_slot,
   input  logic [dlht_pkg::TIME_BITS-1:0]        in_time,
   input  dlht_pkg::dlht_cmd_type                cmd,
   output dlht_pkg::dlht_stat_type               stat,
   dlht_rsp_if.source                            rsp_chan
);
   import dlht_pkg::*;

   localparam int KEY_W  = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      dlht_state_type      state;
      logic [RUN_BITS-1:0] srun;
      logic [RUN_BITS-1:0] frun;
      logic [TIME_BITS-1:0] seen;
   } entry_type;

   localparam int ENT_W = $bits(entry_type);

   // request word
   dlht_func_type        func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SLOT_BITS-1:0] sidx_ff, sidx_in;
   logic [TIME_BITS-1:0] time_ff, time_in;

   // configuration
   logic                 enable_ff, enable_in;
   logic [RUN_BITS-1:0]  sthr_ff, sthr_in;
   logic [RUN_BITS-1:0]  fthr_ff, fthr_in;
   logic                 pdm_ff, pdm_in;

   // table bookkeeping and scan
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     online_ff, online_in;
   logic [ERR_BITS-1:0]  err_ff, err_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [ONLINE_BITS-1:0] pub_n_ff, pub_n_in;

   // response register
   dlht_rsp_type         out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // memory port
   logic                 ram_we, ram_re;
   logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
   logic [ENT_W-1:0]     ram_wdata, ram_rdata;
   entry_type            ent_rd;

   // update
   entry_type            base, upd;
   dlht_event_type       upd_ev;
   logic [SLOT_W-1:0]    upd_slot;
   logic [CNT_W-1:0]     online_upd;
   logic [ERR_BITS-1:0]  err_upd;
   logic [RUN_BITS-1:0]  thr_s, thr_f;

   logic                 slot_ok, hit, out_free, pub_last, table_full, out_load;

   assign ent_rd = entry_type'(ram_rdata);

   assign slot_ok    = (32'(sidx_ff) < 32'(fill_ff));
   assign table_full = (fill_ff >= CNT_W'(TABLE_SLOTS));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign out_load   = cmd.commit || cmd.out_pub || cmd.out_slot || cmd.out_full;
   assign pub_last   = ((32'(pub_n_ff) + 32'd1) == 32'(online_ff)) ||
                       (pub_n_ff == ONLINE_BITS'(MAX_RESULTS - 1));

   always_comb begin
      hit = 1'b0;
      if (chk_vld_ff) begin
         if (func_ff == FN_REPUB) begin
            hit = (ent_rd.state == ST_ONLINE);
         end else begin
            hit = (ent_rd.key == key_ff);
         end
      end
   end

   always_comb begin
      stat.func       = func_ff;
      stat.enabled    = enable_ff;
      stat.hit        = hit;
      stat.scan_done  = !hit && (rd_idx_ff >= fill_ff);
      stat.table_full = table_full;
      stat.out_free   = out_free;
      stat.pub_last   = pub_last;
   end

   // entry update for a success or failure event
   always_comb begin
      if (cmd.use_new) begin
         base.key   = key_ff;
         base.state = ST_UNKNOWN;
         base.srun  = '0;
         base.frun  = '0;
         base.seen  = '0;
         upd_slot   = fill_ff[SLOT_W-1:0];
      end else begin
         base     = ent_rd;
         upd_slot = chk_idx_ff;
      end
      thr_s      = (sthr_ff == '0) ? RUN_BITS'(1) : sthr_ff;
      thr_f      = (fthr_ff == '0) ? RUN_BITS'(1) : fthr_ff;
      upd        = base;
      upd_ev     = EV_NONE;
      online_upd = online_ff;
      err_upd    = err_ff;
      if (func_ff == FN_SUCCESS) begin
         upd.frun = '0;
         upd.srun = (base.srun == RUN_MAX) ? base.srun : base.srun + RUN_BITS'(1);
         upd.seen = time_ff;
         if (base.state != ST_ONLINE && upd.srun >= thr_s) begin
            upd.state  = ST_ONLINE;
            upd_ev     = EV_ONLINE;
            online_upd = online_ff + CNT_W'(1);
         end
      end else begin
         upd.srun = '0;
         upd.frun = (base.frun == RUN_MAX) ? base.frun : base.frun + RUN_BITS'(1);
         err_upd  = (err_ff == ERR_MAX) ? err_ff : err_ff + ERR_BITS'(1);
         if (base.state != ST_OFFLINE && upd.frun >= thr_f) begin
            upd.state = ST_OFFLINE;
            upd_ev    = EV_OFFLINE;
            if (base.state == ST_ONLINE) begin
               online_upd = online_ff - CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      ram_we    = cmd.commit;
      ram_waddr = upd_slot;
      ram_wdata = ENT_W'(upd);
      ram_re    = (cmd.read_slot && slot_ok) || cmd.scan_step;
      ram_raddr = cmd.read_slot ? SLOT_W'(sidx_ff) : rd_idx_ff[SLOT_W-1:0];
   end

   dlht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request word, configuration and counters
   always_comb begin
      func_in = func_ff;
      key_in  = key_ff;
      sidx_in = sidx_ff;
      time_in = time_ff;
      if (cmd.accept) begin
         func_in = dlht_func_type'(in_func);
         key_in  = in_key[KEY_W-1:0];
         sidx_in = in_slot;
         time_in = in_time;
      end

      enable_in = enable_ff;
      sthr_in   = sthr_ff;
      fthr_in   = fthr_ff;
      pdm_in    = pdm_ff;
      if (csr_write_enable) begin
         case (dlht_csr_type'(csr_index))
            CSR_ENABLE:   enable_in = csr_write_data[0];
            CSR_SUCC_THR: sthr_in   = csr_write_data[RUN_BITS-1:0];
            CSR_FAIL_THR: fthr_in   = csr_write_data[RUN_BITS-1:0];
            CSR_PER_DEV:  pdm_in    = csr_write_data[0];
            default: ;
         endcase
      end

      fill_in   = fill_ff;
      online_in = online_ff;
      err_in    = err_ff;
      if (cmd.commit) begin
         online_in = online_upd;
         err_in    = err_upd;
         if (cmd.use_new) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end

      rd_idx_in  = rd_idx_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = chk_vld_ff;
      pub_n_in   = pub_n_ff;
      if (cmd.scan_start) begin
         rd_idx_in  = '0;
         chk_vld_in = 1'b0;
         pub_n_in   = '0;
      end else if (cmd.scan_step) begin
         // read ahead one slot while the previous one is checked
         rd_idx_in  = rd_idx_ff + CNT_W'(1);
         chk_idx_in = rd_idx_ff[SLOT_W-1:0];
         chk_vld_in = 1'b1;
      end else if (cmd.scan_resume) begin
         rd_idx_in  = CNT_W'(chk_idx_ff) + CNT_W'(1);
         chk_vld_in = 1'b0;
      end
      if (cmd.out_pub) begin
         pub_n_in = pub_n_ff + ONLINE_BITS'(1);
      end
   end

   // response word
   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.commit) begin
         out_in.event_res         = upd_ev;
         out_in.slot              = SLOT_BITS'(upd_slot);
         out_in.key_out           = KEY_FIELD_BITS'(upd.key);
         out_in.entry_valid       = 1'b1;
         out_in.entry_state       = upd.state;
         out_in.last_ok_ms        = upd.seen;
         out_in.fail_run          = upd.frun;
         out_in.online_count      = online_sat(32'(online_upd));
         out_in.error_total       = err_upd;
         out_in.per_device_report = pdm_ff;
         out_in.last              = 1'b1;
      end else if (cmd.out_pub || (cmd.out_slot && slot_ok)) begin
         out_in.event_res         = cmd.out_pub ? EV_REPUB : EV_NONE;
         out_in.slot              = cmd.out_pub ? SLOT_BITS'(chk_idx_ff) : sidx_ff;
         out_in.key_out           = KEY_FIELD_BITS'(ent_rd.key);
         out_in.entry_valid       = 1'b1;
         out_in.entry_state       = ent_rd.state;
         out_in.last_ok_ms        = ent_rd.seen;
         out_in.fail_run          = ent_rd.frun;
         out_in.online_count      = online_sat(32'(online_ff));
         out_in.error_total       = err_ff;
         out_in.per_device_report = cmd.out_pub;
         out_in.last              = cmd.out_pub ? pub_last : 1'b1;
      end else if (cmd.out_slot || cmd.out_full) begin
         out_in.event_res         = cmd.out_full ? EV_FULL : EV_NONE;
         out_in.slot              = cmd.out_full ? '0 : sidx_ff;
         out_in.key_out           = cmd.out_full ? KEY_FIELD_BITS'(key_ff) : '0;
         out_in.entry_valid       = 1'b0;
         out_in.entry_state       = ST_UNKNOWN;
         out_in.last_ok_ms        = '0;
         out_in.fail_run          = '0;
         out_in.online_count      = online_sat(32'(online_ff));
         out_in.error_total       = err_ff;
         out_in.per_device_report = cmd.out_full ? pdm_ff : 1'b0;
         out_in.last              = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_in_reset: begin
            enable_ff <= 1'b1;
            sthr_ff   <= SUCC_THR_RST;
            fthr_ff   <= FAIL_THR_RST;
            pdm_ff    <= 1'b1;
         end
         fill_ff      <= '0;
         online_ff    <= '0;
         err_ff       <= '0;
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         pub_n_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         sthr_ff      <= sthr_in;
         fthr_ff      <= fthr_in;
         pdm_ff       <= pdm_in;
         fill_ff      <= fill_in;
         online_ff    <= online_in;
         err_ff       <= err_in;
         rd_idx_ff    <= rd_idx_in;
         chk_vld_ff   <= chk_vld_in;
         pub_n_ff     <= pub_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      key_ff     <= key_in;
      sidx_ff    <= sidx_in;
      time_ff    <= time_in;
      chk_idx_ff <= chk_idx_in;
      out_ff     <= out_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.event_res         = out_ff.event_res;
   assign rsp_chan.slot              = out_ff.slot;
   assign rsp_chan.key_out           = out_ff.key_out;
   assign rsp_chan.entry_valid       = out_ff.entry_valid;
   assign rsp_chan.entry_state       = out_ff.entry_state;
   assign rsp_chan.last_ok_ms        = out_ff.last_ok_ms;
   assign rsp_chan.fail_run          = out_ff.fail_run;
   assign rsp_chan.online_count      = out_ff.online_count;
   assign rsp_chan.error_total       = out_ff.error_total;
   assign rsp_chan.per_device_report = out_ff.per_device_report;
   assign rsp_chan.last              = out_ff.last;

   `DLHT_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(TABLE_SLOTS))
   `DLHT_ASSERT(a_online_le_fill, clock, reset, online_ff <= fill_ff)
   `DLHT_ASSERT(a_load_when_free, clock, reset, out_load |-> out_free)
   `DLHT_ASSERT_NEXT(a_fill_on_commit, clock, reset, !cmd.commit, $stable(fill_ff))
   `DLHT_ASSERT_NEXT(a_err_on_failure, clock, reset, !(cmd.commit && func_ff == FN_FAILURE), $stable(err_ff))
endmodule

// ===== dv/device_liveness_hysteresis_table_tb.sv =====
// Self-checking testbench for the device liveness table: random and directed words, ledger check.
module device_liveness_hysteresis_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dlht_pkg::*;

   localparam int SLOTS      = 16;
   localparam int POOL_KEYS  = 20;
   localparam int HOLD_TICKS = 48;

   // Tracks the table as the block should hold it and the result words still owed.
   class liveness_ledger;
      logic [KEY_FIELD_BITS-1:0] keys[SLOTS];
      bit                        used[SLOTS];
      dlht_state_type            dev_state[SLOTS];
      logic [RUN_BITS-1:0]       succ_run[SLOTS];
      logic [RUN_BITS-1:0]       fail_run[SLOTS];
      logic [TIME_BITS-1:0]      seen_ms[SLOTS];
      logic [ERR_BITS-1:0]       err_total;
      bit                        enabled;
      logic [RUN_BITS-1:0]       succ_thr;
      logic [RUN_BITS-1:0]       fail_thr;
      bit                        per_dev;
      dlht_rsp_type              due_words[$];
      int                        failures;
      int                        reports;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            keys[i]      = '0;
            used[i]      = 1'b0;
            dev_state[i] = ST_UNKNOWN;
            succ_run[i]  = '0;
            fail_run[i]  = '0;
            seen_ms[i]   = '0;
         end
         err_total = '0;
         enabled   = 1'b1;
         succ_thr  = SUCC_THR_RST;
         fail_thr  = FAIL_THR_RST;
         per_dev   = 1'b1;
         failures  = 0;
         reports   = 0;
      endfunction

      function void write_reg(dlht_csr_type idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_ENABLE:   enabled  = val[0];
            CSR_SUCC_THR: succ_thr = val;
            CSR_FAIL_THR: fail_thr = val;
            CSR_PER_DEV:  per_dev  = val[0];
            default: ;
         endcase
      endfunction

      function logic [ONLINE_BITS-1:0] online_now();
         int n;
         n = 0;
         for (int i = 0; i < SLOTS; i++)
            if (used[i] && dev_state[i] == ST_ONLINE) n++;
         if (n > ONLINE_SAT) n = ONLINE_SAT;
         return ONLINE_BITS'(n);
      endfunction

      function dlht_rsp_type entry_word(dlht_event_type ev, int i, bit report, bit fin);
         dlht_rsp_type w;
         w.event_res         = ev;
         w.slot              = SLOT_BITS'(i);
         w.key_out           = keys[i];
         w.entry_valid       = 1'b1;
         w.entry_state       = dev_state[i];
         w.last_ok_ms        = seen_ms[i];
         w.fail_run          = fail_run[i];
         w.online_count      = online_now();
         w.error_total       = err_total;
         w.per_device_report = report;
         w.last              = fin;
         return w;
      endfunction

      // Word for an empty slot read or a full table: no entry contents.
      function dlht_rsp_type blank_word(dlht_event_type ev, logic [SLOT_BITS-1:0] slot,
                                        logic [KEY_FIELD_BITS-1:0] key, bit report);
         dlht_rsp_type w;
         w.event_res         = ev;
         w.slot              = slot;
         w.key_out           = key;
         w.entry_valid       = 1'b0;
         w.entry_state       = ST_UNKNOWN;
         w.last_ok_ms        = '0;
         w.fail_run          = '0;
         w.online_count      = online_now();
         w.error_total       = err_total;
         w.per_device_report = report;
         w.last              = 1'b1;
         return w;
      endfunction

      // Find the key's slot, or claim the lowest free one; -1 when full.
      function int find_slot(logic [KEY_FIELD_BITS-1:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (used[i] && keys[i] == key) return i;
         for (int i = 0; i < SLOTS; i++)
            if (!used[i]) begin
               used[i]      = 1'b1;
               keys[i]      = key;
               dev_state[i] = ST_UNKNOWN;
               succ_run[i]  = '0;
               fail_run[i]  = '0;
               return i;
            end
         return -1;
      endfunction

      function void note_request(dlht_func_type fn, logic [KEY_FIELD_BITS-1:0] key,
                                 logic [SLOT_BITS-1:0] sidx, logic [TIME_BITS-1:0] t);
         int                  i;
         int                  last_on;
         logic [RUN_BITS-1:0] thr;
         dlht_event_type      ev;
         if (fn == FN_READ) begin
            if (used[sidx]) due_words.push_back(entry_word(EV_NONE, int'(sidx), 1'b0, 1'b1));
            else due_words.push_back(blank_word(EV_NONE, sidx, '0, 1'b0));
            return;
         end
         if (!enabled) return;
         if (fn == FN_REPUB) begin
            last_on = -1;
            for (i = 0; i < SLOTS; i++)
               if (used[i] && dev_state[i] == ST_ONLINE) last_on = i;
            for (i = 0; i < SLOTS; i++)
               if (used[i] && dev_state[i] == ST_ONLINE)
                  due_words.push_back(entry_word(EV_REPUB, i, 1'b1, i == last_on));
            return;
         end
         i = find_slot(key);
         if (i < 0) begin
            due_words.push_back(blank_word(EV_FULL, '0, key, per_dev));
            return;
         end
         ev = EV_NONE;
         if (fn == FN_SUCCESS) begin
            thr = (succ_thr == 0) ? 4'd1 : succ_thr;
            fail_run[i] = '0;
            if (succ_run[i] < RUN_MAX) succ_run[i]++;
            seen_ms[i] = t;
            if (dev_state[i] != ST_ONLINE && succ_run[i] >= thr) begin
               dev_state[i] = ST_ONLINE;
               ev = EV_ONLINE;
            end
         end else begin
            thr = (fail_thr == 0) ? 4'd1 : fail_thr;
            succ_run[i] = '0;
            if (fail_run[i] < RUN_MAX) fail_run[i]++;
            if (err_total != ERR_MAX) err_total++;
            if (dev_state[i] != ST_OFFLINE && fail_run[i] >= thr) begin
               dev_state[i] = ST_OFFLINE;
               ev = EV_OFFLINE;
            end
         end
         due_words.push_back(entry_word(ev, i, per_dev, 1'b1));
      endfunction

      function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            if (reports < 60)
               $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            reports++;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_result(dlht_rsp_type got);
         dlht_rsp_type want;
         bit           ok;
         if (due_words.size() == 0) begin
            if (reports < 60)
               $display("%0t: unexpected word expected none actual %h", $time, got);
            reports++;
            failures++;
            return;
         end
         want = due_words.pop_front();
         ok = 1'b1;
         ok &= field_ok("event_res", want.event_res, got.event_res);
         ok &= field_ok("slot", want.slot, got.slot);
         ok &= field_ok("key_out", want.key_out, got.key_out);
         ok &= field_ok("entry_valid", want.entry_valid, got.entry_valid);
         ok &= field_ok("entry_state", want.entry_state, got.entry_state);
         ok &= field_ok("last_ok_ms", want.last_ok_ms, got.last_ok_ms);
         ok &= field_ok("fail_run", want.fail_run, got.fail_run);
         ok &= field_ok("online_count", want.online_count, got.online_count);
         ok &= field_ok("error_total", want.error_total, got.error_total);
         ok &= field_ok("per_device_report", want.per_device_report, got.per_device_report);
         ok &= field_ok("last", want.last, got.last);
         if (!ok) failures++;
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   dlht_req_if req_chan();
   dlht_rsp_if rsp_chan();

   device_liveness_hysteresis_table dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   liveness_ledger            ledger = new();
   int                        req_idle_pct = 17;
   int                        rsp_idle_pct = 45;
   logic [KEY_FIELD_BITS-1:0] key_pool[POOL_KEYS];

   always #2ns clock = ~clock;

   // Hold valid high until the word is taken; sample the handshake mid-cycle.
   task automatic send_word(dlht_func_type fn, logic [KEY_FIELD_BITS-1:0] key,
                            logic [SLOT_BITS-1:0] sidx, logic [TIME_BITS-1:0] t);
      bit taken;
      // idle at random before driving the word
      while (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= fn;
      req_chan.device_key <= key;
      req_chan.slot_index <= sidx;
      req_chan.time_ms    <= t;
      forever begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
         if (taken) break;
      end
      ledger.note_request(fn, key, sidx, t);
   endtask

   // Drop valid and wait for every owed word, then let silent work finish.
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (ledger.due_words.size() != 0) @(posedge clock);
      repeat (HOLD_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(dlht_csr_type idx, logic [CSR_DATA_BITS-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      ledger.write_reg(idx, val);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(bit en, logic [RUN_BITS-1:0] s_thr, logic [RUN_BITS-1:0] f_thr,
                             bit pd);
      write_reg(CSR_ENABLE, CSR_DATA_BITS'(en));
      write_reg(CSR_SUCC_THR, s_thr);
      write_reg(CSR_FAIL_THR, f_thr);
      write_reg(CSR_PER_DEV, CSR_DATA_BITS'(pd));
   endtask

   // Mostly streaks of one key and one event kind, with reads and republish between.
   task automatic run_phase(bit en, logic [RUN_BITS-1:0] s_thr, logic [RUN_BITS-1:0] f_thr,
                            bit pd, int n_words, int pool_n);
      int                        sent;
      int                        pick;
      int                        streak;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [TIME_BITS-1:0]      t;
      dlht_func_type             fn;
      quiesce();
      set_config(en, s_thr, f_thr, pd);
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_word(FN_READ, 16'($urandom), 4'($urandom), {16'($urandom), $urandom});
            sent++;
         end else if (pick < 18) begin
            send_word(FN_REPUB, 16'($urandom), 4'($urandom), {16'($urandom), $urandom});
            sent++;
         end else begin
            key = key_pool[$urandom_range(0, pool_n - 1)];
            fn = $urandom_range(0, 1) ? FN_FAILURE : FN_SUCCESS;
            streak = (pick < 80) ? $urandom_range(1, 5) : $urandom_range(1, 18);
            repeat (streak) begin
               case ($urandom_range(0, 9))
                  0: t = '0;
                  1: t = '1;
                  default: t = {16'($urandom), $urandom};
               endcase
               send_word(fn, key, 4'($urandom), t);
               sent++;
            end
         end
      end
   endtask

   // Receiver: stall at random, take words sampled mid-cycle.
   initial begin
      dlht_rsp_type got;
      bit           take;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         take                  = (rsp_chan.valid === 1'b1) && (rsp_chan.ready === 1'b1);
         got.event_res         = dlht_event_type'(rsp_chan.event_res);
         got.slot              = rsp_chan.slot;
         got.key_out           = rsp_chan.key_out;
         got.entry_valid       = rsp_chan.entry_valid;
         got.entry_state       = dlht_state_type'(rsp_chan.entry_state);
         got.last_ok_ms        = rsp_chan.last_ok_ms;
         got.fail_run          = rsp_chan.fail_run;
         got.online_count      = rsp_chan.online_count;
         got.error_total       = rsp_chan.error_total;
         got.per_device_report = rsp_chan.per_device_report;
         got.last              = rsp_chan.last;
         @(posedge clock);
         if (take && !reset) ledger.check_result(got);
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      #2ms;
      $display("device_liveness_hysteresis_table: mismatch");
      $finish;
   end

   initial begin
      bit clash;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_ENABLE;
      csr_write_data      <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FN_SUCCESS;
      req_chan.device_key <= '0;
      req_chan.slot_index <= '0;
      req_chan.time_ms    <= '0;

      // Distinct pool keys, none equal to the directed ones
      for (int i = 0; i < POOL_KEYS; i++) begin
         do begin
            key_pool[i] = 16'($urandom);
            clash = key_pool[i] == 16'h0000 || key_pool[i] == 16'hFFFF ||
                    key_pool[i] == 16'h5AA5;
            for (int j = 0; j < i; j++)
               if (key_pool[j] == key_pool[i]) clash = 1'b1;
         end while (clash);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: empty reads, republish with nothing online, then events
      send_word(FN_READ, 16'h0000, 4'd0, '0);
      send_word(FN_READ, 16'hFFFF, 4'd15, '1);
      send_word(FN_REPUB, 16'h0000, 4'd0, '0);
      send_word(FN_SUCCESS, 16'h0000, 4'd15, '0);
      send_word(FN_SUCCESS, 16'h0000, 4'd0, '1);
      send_word(FN_REPUB, 16'hFFFF, 4'd15, '1);
      send_word(FN_FAILURE, 16'hFFFF, 4'd0, 48'h5555_5555_5555);
      send_word(FN_FAILURE, 16'hFFFF, 4'd0, 48'hAAAA_AAAA_AAAA);
      send_word(FN_FAILURE, 16'hFFFF, 4'd15, '0);
      send_word(FN_READ, 16'h0000, 4'd1, '0);
      send_word(FN_FAILURE, 16'h0000, 4'd3, '0);
      send_word(FN_FAILURE, 16'h0000, 4'd3, '0);
      send_word(FN_FAILURE, 16'h0000, 4'd3, '0);
      send_word(FN_SUCCESS, 16'h0000, 4'd0, 48'h0000_0000_03E8);

      // Disabled: events and republish silent, reads still answered
      quiesce();
      write_reg(CSR_ENABLE, 4'd0);
      send_word(FN_SUCCESS, 16'h5AA5, 4'd0, '1);
      send_word(FN_FAILURE, 16'h0000, 4'd0, '0);
      send_word(FN_REPUB, 16'h0000, 4'd0, '0);
      send_word(FN_READ, 16'h0000, 4'd0, '0);

      // Zero thresholds behave as one; gateway refresh reporting
      quiesce();
      set_config(1'b1, 4'd0, 4'd0, 1'b0);
      send_word(FN_SUCCESS, 16'h5AA5, 4'd2, 48'h8000_0000_0001);
      send_word(FN_FAILURE, 16'h5AA5, 4'd2, '0);
      send_word(FN_SUCCESS, 16'h5AA5, 4'd2, 48'h7FFF_FFFF_FFFE);
      send_word(FN_REPUB, 16'h5AA5, 4'd0, '0);
      send_word(FN_READ, 16'h0000, 4'd2, '0);

      req_idle_pct = 17;
      rsp_idle_pct = 45;
      run_phase(1'b1, 4'd2, 4'd3, 1'b1, 60, 12);
      run_phase(1'b1, 4'd1, 4'd1, 1'b0, 50, 12);

      req_idle_pct = 45;
      rsp_idle_pct = 17;
      run_phase(1'b0, 4'd5, 4'd5, 1'b1, 20, 12);
      run_phase(1'b1, 4'd15, 4'd15, 1'b1, 70, 12);

      // Wider key pool fills the table and reaches the full case
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(1'b1, 4'd4, 4'd2, 1'b0, 60, POOL_KEYS);
      run_phase(1'b1, 4'd0, 4'd9, 1'b1, 30, POOL_KEYS);
      run_phase(1'b1, 4'd3, 4'd3, 1'b0, 30, POOL_KEYS);

      quiesce();
      if (ledger.failures == 0 && ledger.due_words.size() == 0) begin
         $display("device_liveness_hysteresis_table: match");
      end else begin
         $display("device_liveness_hysteresis_table: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dlht_pkg.sv
rtl/dlht_req_if.sv
rtl/dlht_rsp_if.sv
rtl/dlht_ram.sv
rtl/dlht_ctrl.sv
rtl/dlht_datapath.sv
rtl/device_liveness_hysteresis_table.sv
dv/device_liveness_hysteresis_table_tb.sv
